// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the Montgomery field ALU. They expect clk and
// rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is held
`define MFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication
`define MFA_ASSERT_IMP(lbl, ante, cons, msg) \
  `MFA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== design/mfa_pkg.sv =====
// ---------------------------------------------------------------------------
// mfa_pkg
// Shared constants and types of the Montgomery field ALU.
// ---------------------------------------------------------------------------
package mfa_pkg;

  localparam int LIMBS        = 6;
  localparam int LIMB_W       = 64;
  localparam int IW           = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int CW           = IW + 1;
  localparam int TW           = IW + 1;
  localparam int NUM_MOD_REGS = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int IDX_OUT_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_N0   = 3'd6;

  // operation codes
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;

  typedef logic [LIMBS-1:0][LIMB_W-1:0] limbs_t;

  typedef struct packed {
    logic [1:0] mode;
    limbs_t     a;
    limbs_t     b;
  } job_t;

  // job queue status towards the front (full) and the back (valid)
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic [LIMB_W-1:0]    limb;
    logic [IDX_OUT_W-1:0] index;
    logic                 last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_COND,
    ST_CLR,
    ST_MLD,
    ST_MMUL,
    ST_MWB,
    ST_PROP
  } back_state_t;

  typedef enum logic [1:0] {
    PH_PROD,
    PH_MINV,
    PH_REDC
  } mul_phase_t;

endpackage

// ===== design/mfa_front.sv =====
// ---------------------------------------------------------------------------
// mfa_front
// Collects operand limbs beat by beat and hands a complete job to the queue
// on the beat marked final.
// ---------------------------------------------------------------------------
module mfa_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           in_mode,
  input  logic [63:0]          in_operand_a_limb,
  input  logic [63:0]          in_operand_b_limb,
  input  logic                 in_final_limb,
  output logic                 job_push,
  output mfa_pkg::job_t        job,
  input  mfa_pkg::q_stat_t     jq_stat
);
  import mfa_pkg::*;

  limbs_t        a_r, b_r, a_nxt, b_nxt;
  logic [CW-1:0] cnt_r;
  logic          accept;

  assign full   = jq_stat.full;
  assign accept = push && !jq_stat.full;

  // merge this beat's limbs; excess limbs are dropped
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (cnt_r < CW'(LIMBS)) begin
      a_nxt[cnt_r[IW-1:0]] = in_operand_a_limb;
      b_nxt[cnt_r[IW-1:0]] = in_operand_b_limb;
    end
    job.mode = in_mode;
    job.a    = a_nxt;
    job.b    = b_nxt;
    job_push = accept && in_final_limb;
  end

  // operand stores, cleared after each job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r   <= '0;
      b_r   <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      if (in_final_limb) begin
        a_r   <= '0;
        b_r   <= '0;
        cnt_r <= '0;
      end else begin
        a_r <= a_nxt;
        b_r <= b_nxt;
        if (cnt_r < CW'(LIMBS)) cnt_r <= cnt_r + CW'(1);
      end
    end
  end

endmodule

// ===== design/mfa_jobq.sv =====
// ---------------------------------------------------------------------------
// mfa_jobq
// Two-entry job queue between the front and the back.
// ---------------------------------------------------------------------------
module mfa_jobq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  mfa_pkg::job_t        job_i,
  input  logic                 pop_i,
  output mfa_pkg::job_t        job_o,
  output mfa_pkg::q_stat_t     stat_o
);
  import mfa_pkg::*;
  `include "assert_macros.svh"

  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign stat_o.valid = (cnt_r != 2'd0);
  assign stat_o.full  = (cnt_r == 2'd2);
  assign job_o        = q_r[rp_r];
  assign do_pop       = pop_i && stat_o.valid;

  // storage
  always_ff @(posedge clk) begin
    if (push_i) q_r[wp_r] <= job_i;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_i) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_i) - 2'(do_pop);
    end
  end

  `MFA_ASSERT_IMP(a_jq_no_overflow, push_i, cnt_r != 2'd2, "job pushed into full queue")
  `MFA_ASSERT(a_jq_push_lands, (push_i && !do_pop) |=> cnt_r != 2'd0, "job lost")

endmodule

// ===== design/mfa_back.sv =====
// ---------------------------------------------------------------------------
// mfa_back
// Sequencer that runs add, subtract or Montgomery multiply on one job with
// a shared 32x32 multiplier, then emits the result limbs into a small queue.
// ---------------------------------------------------------------------------
module mfa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  mfa_pkg::q_stat_t     jq_stat,
  input  mfa_pkg::job_t        job_i,
  output logic                 job_pop,
  input  logic                 pop,
  output logic                 empty,
  output mfa_pkg::res_t        res_o
);
  import mfa_pkg::*;
  `include "assert_macros.svh"

  // configuration
  logic [LIMB_W-1:0] m_r [LIMBS];
  logic [LIMB_W-1:0] n0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < LIMBS; n++) m_r[n] <= '0;
      n0_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_N0) begin
        n0_r <= cfg_data;
      end else begin
        for (int n = 0; n < LIMBS; n++) begin
          if (n < NUM_MOD_REGS && cfg_index == CFG_MOD0 + CFG_IDX_W'(n)) m_r[n] <= cfg_data;
        end
      end
    end
  end

  // working registers
  back_state_t       st_r, st_nxt;
  logic              emit_r, emit_nxt;
  mul_phase_t        ph_r, ph_nxt;
  logic [1:0]        mode_r, mode_nxt;
  limbs_t            a_r, a_nxt, b_r, b_nxt;
  logic [LIMB_W-1:0] t_r [2*LIMBS];
  logic [LIMB_W-1:0] t_nxt [2*LIMBS];
  logic [LIMB_W-1:0] dr_r [LIMBS];
  logic [LIMB_W-1:0] dr_nxt [LIMBS];
  logic [IW-1:0]     i_r, i_nxt, j_r, j_nxt;
  logic [TW-1:0]     k_r, k_nxt;
  logic [LIMB_W-1:0] cy_r, cy_nxt, x_r, x_nxt, y_r, y_nxt, mi_r, mi_nxt;
  logic [127:0]      acc_r, acc_nxt;
  logic [1:0]        ms_r, ms_nxt;
  logic              c_r, c_nxt, f1_r, f1_nxt, use_dr_r, use_dr_nxt;

  // output queue
  res_t              oq_r [2];
  logic              oq_wp_r, oq_rp_r;
  logic [1:0]        oq_cnt_r;
  logic              oq_full, oq_empty, oq_push, oq_pop;
  res_t              oq_din;

  logic [TW-1:0]     ridx, rbase;
  logic [LIMB_W-1:0] t_rd;
  logic [64:0]       s65, d65;
  logic [31:0]       xh, yh;
  logic [63:0]       pp;
  logic [127:0]      pp_sh, redc_top;
  logic              row_end;

  assign rbase = (mode_r == MODE_MUL) ? TW'(LIMBS) : '0;

  // single read port on the scratch registers
  always_comb begin
    case (st_r)
      ST_COND:  ridx = rbase + TW'(i_r);
      ST_MLD: begin
        if (ph_r == PH_MINV) ridx = TW'(i_r);
        else                 ridx = TW'(i_r) + TW'(j_r);
      end
      ST_MWB:   ridx = TW'(i_r) + TW'(LIMBS);
      ST_PROP:  ridx = k_r;
      default:  ridx = rbase + TW'(i_r);
    endcase
  end
  assign t_rd = t_r[ridx];

  // partial product of the shared multiplier
  assign xh = ms_r[0] ? x_r[63:32] : x_r[31:0];
  assign yh = ms_r[1] ? y_r[63:32] : y_r[31:0];
  assign pp = 64'(xh) * 64'(yh);
  always_comb begin
    case (ms_r)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = 128'(pp) << 32;
    endcase
  end

  assign redc_top = 128'(t_rd) + 128'(acc_r[127:64]);

  // sequencer: next state and datapath
  always_comb begin
    st_nxt     = st_r;
    emit_nxt   = emit_r;
    ph_nxt     = ph_r;
    mode_nxt   = mode_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    t_nxt      = t_r;
    dr_nxt     = dr_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    cy_nxt     = cy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    mi_nxt     = mi_r;
    acc_nxt    = acc_r;
    ms_nxt     = ms_r;
    c_nxt      = c_r;
    f1_nxt     = f1_r;
    use_dr_nxt = use_dr_r;
    job_pop    = 1'b0;
    oq_push    = 1'b0;
    row_end    = 1'b0;
    s65        = 65'(t_rd) + 65'(m_r[i_r]) + 65'(c_r);
    d65        = 65'(t_rd) - 65'(m_r[i_r]) - 65'(c_r);
    oq_din.limb  = use_dr_r ? dr_r[i_r] : t_rd;
    oq_din.index = IDX_OUT_W'(i_r);
    oq_din.last  = (i_r == IW'(LIMBS - 1));

    if (emit_r) begin
      // result limbs out, one per cycle unless the queue is full
      if (!oq_full) begin
        oq_push = 1'b1;
        if (i_r == IW'(LIMBS - 1)) begin
          emit_nxt = 1'b0;
          i_nxt    = '0;
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (jq_stat.valid) begin
            job_pop  = 1'b1;
            mode_nxt = job_i.mode;
            a_nxt    = job_i.a;
            b_nxt    = job_i.b;
            i_nxt    = '0;
            j_nxt    = '0;
            c_nxt    = 1'b0;
            cy_nxt   = '0;
            case (job_i.mode)
              MODE_ADD, MODE_SUB: st_nxt = ST_ADDSUB;
              MODE_MUL:           st_nxt = ST_CLR;
              default: begin
                // unused code gives a zero result
                emit_nxt = 1'b1;
                for (int n = 0; n < LIMBS; n++) dr_nxt[n] = '0;
                use_dr_nxt = 1'b1;
              end
            endcase
          end
        end

        ST_ADDSUB: begin
          s65 = 65'(a_r[i_r]) + 65'(b_r[i_r]) + 65'(c_r);
          d65 = 65'(a_r[i_r]) - 65'(b_r[i_r]) - 65'(c_r);
          if (mode_r == MODE_SUB) begin
            t_nxt[TW'(i_r)] = d65[63:0];
            c_nxt = d65[64];
          end else begin
            t_nxt[TW'(i_r)] = s65[63:0];
            c_nxt = s65[64];
          end
          if (i_r == IW'(LIMBS - 1)) begin
            f1_nxt = (mode_r == MODE_SUB) ? d65[64] : s65[64];
            c_nxt  = 1'b0;
            i_nxt  = '0;
            st_nxt = ST_COND;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end

        ST_COND: begin
          // corrected value alongside the raw one
          if (mode_r == MODE_SUB) begin
            dr_nxt[i_r] = s65[63:0];
            c_nxt = s65[64];
          end else begin
            dr_nxt[i_r] = d65[63:0];
            c_nxt = d65[64];
          end
          if (i_r == IW'(LIMBS - 1)) begin
            case (mode_r)
              MODE_ADD: use_dr_nxt = f1_r || !d65[64];
              MODE_SUB: use_dr_nxt = f1_r;
              default:  use_dr_nxt = !d65[64];
            endcase
            i_nxt    = '0;
            st_nxt   = ST_IDLE;
            emit_nxt = 1'b1;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end

        ST_CLR: begin
          for (int n = 0; n < 2 * LIMBS; n++) t_nxt[n] = '0;
          ph_nxt = PH_PROD;
          st_nxt = ST_MLD;
        end

        ST_MLD: begin
          case (ph_r)
            PH_PROD: begin
              x_nxt   = a_r[j_r];
              y_nxt   = b_r[i_r];
              acc_nxt = 128'(t_rd) + 128'(cy_r);
            end
            PH_MINV: begin
              x_nxt   = t_rd;
              y_nxt   = n0_r;
              acc_nxt = '0;
            end
            default: begin
              x_nxt   = mi_r;
              y_nxt   = m_r[j_r];
              acc_nxt = 128'(t_rd) + 128'(cy_r);
            end
          endcase
          ms_nxt = 2'd0;
          st_nxt = ST_MMUL;
        end

        ST_MMUL: begin
          acc_nxt = acc_r + pp_sh;
          ms_nxt  = ms_r + 2'd1;
          if (ms_r == 2'd3) st_nxt = ST_MWB;
        end

        ST_MWB: begin
          st_nxt = ST_MLD;
          case (ph_r)
            PH_PROD: begin
              t_nxt[TW'(i_r) + TW'(j_r)] = acc_r[63:0];
              cy_nxt = acc_r[127:64];
              if (j_r == IW'(LIMBS - 1)) begin
                t_nxt[TW'(i_r) + TW'(LIMBS)] = acc_r[127:64];
                cy_nxt = '0;
                j_nxt  = '0;
                if (i_r == IW'(LIMBS - 1)) begin
                  i_nxt  = '0;
                  ph_nxt = PH_MINV;
                end else begin
                  i_nxt = i_r + IW'(1);
                end
              end else begin
                j_nxt = j_r + IW'(1);
              end
            end
            PH_MINV: begin
              mi_nxt = acc_r[63:0];
              ph_nxt = PH_REDC;
              j_nxt  = '0;
              cy_nxt = '0;
            end
            default: begin
              t_nxt[TW'(i_r) + TW'(j_r)] = acc_r[63:0];
              cy_nxt = acc_r[127:64];
              if (j_r == IW'(LIMBS - 1)) begin
                // fold the row carry into the top limb
                t_nxt[TW'(i_r) + TW'(LIMBS)] = redc_top[63:0];
                cy_nxt = '0;
                j_nxt  = '0;
                if (redc_top[64] && (i_r != IW'(LIMBS - 1))) begin
                  k_nxt  = TW'(i_r) + TW'(LIMBS + 1);
                  st_nxt = ST_PROP;
                end else begin
                  row_end = 1'b1;
                end
              end else begin
                j_nxt = j_r + IW'(1);
              end
            end
          endcase
        end

        ST_PROP: begin
          t_nxt[k_r] = t_rd + 64'd1;
          if (t_rd != '1 || k_r == TW'(2 * LIMBS - 1)) row_end = 1'b1;
          else k_nxt = k_r + TW'(1);
        end

        default: st_nxt = ST_IDLE;
      endcase

      // next reduction row or the final compare
      if (row_end) begin
        if (i_r == IW'(LIMBS - 1)) begin
          i_nxt  = '0;
          c_nxt  = 1'b0;
          st_nxt = ST_COND;
        end else begin
          i_nxt  = i_r + IW'(1);
          ph_nxt = PH_MINV;
          st_nxt = ST_MLD;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      emit_r <= 1'b0;
      ph_r   <= PH_PROD;
      i_r    <= '0;
      j_r    <= '0;
      k_r    <= '0;
      ms_r   <= '0;
      c_r    <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      emit_r <= emit_nxt;
      ph_r   <= ph_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      k_r    <= k_nxt;
      ms_r   <= ms_nxt;
      c_r    <= c_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    t_r      <= t_nxt;
    dr_r     <= dr_nxt;
    cy_r     <= cy_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    mi_r     <= mi_nxt;
    acc_r    <= acc_nxt;
    f1_r     <= f1_nxt;
    use_dr_r <= use_dr_nxt;
  end

  // result queue
  assign oq_full  = (oq_cnt_r == 2'd2);
  assign oq_empty = (oq_cnt_r == 2'd0);
  assign oq_pop   = pop && !oq_empty;
  assign empty    = oq_empty;
  assign res_o    = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[oq_wp_r] <= oq_din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_push) oq_wp_r <= ~oq_wp_r;
      if (oq_pop)  oq_rp_r <= ~oq_rp_r;
      oq_cnt_r <= oq_cnt_r + 2'(oq_push) - 2'(oq_pop);
    end
  end

  `MFA_ASSERT(a_emit_lands, (emit_r && !oq_full) |=> !oq_empty, "emitted beat lost")
  `MFA_ASSERT(a_job_taken, (st_r == ST_IDLE && !emit_r && jq_stat.valid) |=> (st_r != ST_IDLE || emit_r), "job not started")
  `MFA_ASSERT_IMP(a_busy_no_pop, job_pop, st_r == ST_IDLE && !emit_r, "job taken while busy")

endmodule

// ===== design/montgomery_field_alu.sv =====
// ---------------------------------------------------------------------------
// montgomery_field_alu
// Modular add, subtract and Montgomery multiply over a configured odd
// modulus, operands and results moved as 64-bit limbs.
// ---------------------------------------------------------------------------
//  channel   ports                                   beat
//  input     push/full, in_*                         one a/b limb pair
//  result    empty/pop, out_*                        one result limb
//  config    cfg_we, cfg_index, cfg_data             one register write
//
//  Input beats are taken one a cycle while full is low; a final beat queues
//  a job (two deep). Add/subtract run an add pass and a correction pass,
//  then LIMBS result beats. Multiply uses one 32x32 multiplier; each 64-bit
//  MAC loads operands, accumulates the partial products and writes back,
//  plus any carry-propagate steps, then LIMBS result beats.
//  Synchronous active-low reset clears control; stalls on either side
//  only back up through the two queues.
// ---------------------------------------------------------------------------
module montgomery_field_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_operand_a_limb,
  input  logic [63:0] in_operand_b_limb,
  input  logic        in_final_limb,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_result_limb,
  output logic [2:0]  out_result_index,
  output logic        out_result_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import mfa_pkg::*;

  logic    job_push, job_pop;
  job_t    job_in, job_out;
  q_stat_t jq_stat;
  res_t    res;

  mfa_front u_front (
    .clk, .rst_n, .push, .full,
    .in_mode, .in_operand_a_limb, .in_operand_b_limb, .in_final_limb,
    .job_push, .job(job_in), .jq_stat
  );

  mfa_jobq u_jobq (
    .clk, .rst_n,
    .push_i(job_push), .job_i(job_in),
    .pop_i(job_pop), .job_o(job_out), .stat_o(jq_stat)
  );

  mfa_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .jq_stat, .job_i(job_out), .job_pop,
    .pop, .empty, .res_o(res)
  );

  assign out_result_limb  = res.limb;
  assign out_result_index = res.index;
  assign out_result_last  = res.last;

endmodule
